@@ rtl/slfc_pkg.sv @@
`default_nettype none

package slfc_pkg;

	localparam int MAX_LINE_DEF = 512;
	localparam int BYTE_W       = 8;
	localparam int LEN_W        = 9;
	localparam int STATUS_W     = 3;
	localparam int PADDR_W      = 4;
	localparam int PDATA_W      = 32;

	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_INIT = 8'h00;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;

	localparam logic [7:0] START_RST = 8'd0;
	localparam logic [7:0] DELIM_RST = 8'd0;
	localparam logic [7:0] SEP_RST   = 8'd9;

	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_DELIM = 2'd1;
	localparam logic [1:0] REG_SEP   = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_IGNORED     = 3'd0,
		ST_CRC_MISSING = 3'd1,
		ST_CRC_BAD     = 3'd2,
		ST_NO_TOPIC    = 3'd3,
		ST_ACCEPTED    = 3'd4
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_marker;
		logic [BYTE_W-1:0] crc_delimiter;
		logic [BYTE_W-1:0] field_separator;
	} cfg_t;

	typedef struct packed {
		status_t           status;
		logic [LEN_W-1:0]  topic_len;
		logic [LEN_W-1:0]  payload_len;
		logic [BYTE_W-1:0] crc;
	} result_t;

	function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
		end
		return v;
	endfunction

	// {valid, nibble}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/slfc_core.sv @@
`default_nettype none

module slfc_core #(
	parameter int MAX_LINE = slfc_pkg::MAX_LINE_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire logic [slfc_pkg::BYTE_W-1:0]  rx_byte,
	input  wire slfc_pkg::cfg_t               cfg,
	output slfc_pkg::result_t                 res
);

	localparam int LW = $clog2(MAX_LINE + 1);

	logic [LW-1:0] line_len_q, line_len_d;
	logic          marker_ok_q, marker_ok_d;
	logic [7:0]    crc_q, crc_d;
	logic [7:0]    crc_dlm_q, crc_dlm_d;
	logic [LW-1:0] dlm_pos_q, dlm_pos_d;
	logic          dlm_seen_q, dlm_seen_d;
	logic [1:0]    n_after_q, n_after_d;
	logic [7:0]    hex_hi_q, hex_hi_d;
	logic [7:0]    hex_lo_q, hex_lo_d;
	logic [LW-1:0] sep_pos_q, sep_pos_d;
	logic          sep_seen_q, sep_seen_d;

	logic [LW-1:0] pos;
	logic [LW:0]   len_inc;
	logic          clr;

	assign pos     = line_len_q - LW'(1);
	assign len_inc = {1'b0, line_len_q} + (LW+1)'(1);

	always_comb begin
		line_len_d  = line_len_q;
		marker_ok_d = marker_ok_q;
		crc_d       = crc_q;
		crc_dlm_d   = crc_dlm_q;
		dlm_pos_d   = dlm_pos_q;
		dlm_seen_d  = dlm_seen_q;
		n_after_d   = n_after_q;
		hex_hi_d    = hex_hi_q;
		hex_lo_d    = hex_lo_q;
		sep_pos_d   = sep_pos_q;
		sep_seen_d  = sep_seen_q;
		clr         = 1'b0;
		if (rx_byte == slfc_pkg::CH_LF) begin
			clr = 1'b1;
		end else if (rx_byte != slfc_pkg::CH_CR) begin
			if (line_len_q == '0) begin
				crc_d       = slfc_pkg::CRC_INIT;
				crc_dlm_d   = '0;
				dlm_pos_d   = '0;
				dlm_seen_d  = 1'b0;
				n_after_d   = '0;
				hex_hi_d    = '0;
				hex_lo_d    = '0;
				sep_pos_d   = '0;
				sep_seen_d  = 1'b0;
				marker_ok_d = (rx_byte == cfg.start_marker);
			end else begin
				if (rx_byte == cfg.crc_delimiter) begin
					crc_dlm_d  = crc_q;
					dlm_pos_d  = pos;
					dlm_seen_d = 1'b1;
					n_after_d  = '0;
				end else if (dlm_seen_q) begin
					if (n_after_q == 2'd0) begin
						hex_hi_d = rx_byte;
					end else if (n_after_q == 2'd1) begin
						hex_lo_d = rx_byte;
					end
					if (n_after_q != 2'd3) begin
						n_after_d = n_after_q + 2'd1;
					end
				end
				if (rx_byte == cfg.field_separator && !sep_seen_q) begin
					sep_seen_d = 1'b1;
					sep_pos_d  = pos;
				end
				crc_d = slfc_pkg::crc_next(crc_q, rx_byte);
			end
			line_len_d = len_inc[LW-1:0];
			if (len_inc > (LW+1)'(MAX_LINE)) begin
				clr = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q  <= '0;
			marker_ok_q <= 1'b0;
			crc_q       <= slfc_pkg::CRC_INIT;
			crc_dlm_q   <= '0;
			dlm_pos_q   <= '0;
			dlm_seen_q  <= 1'b0;
			n_after_q   <= '0;
			hex_hi_q    <= '0;
			hex_lo_q    <= '0;
			sep_pos_q   <= '0;
			sep_seen_q  <= 1'b0;
		end else if (step) begin
			if (clr) begin
				line_len_q  <= '0;
				marker_ok_q <= 1'b0;
				crc_q       <= slfc_pkg::CRC_INIT;
				crc_dlm_q   <= '0;
				dlm_pos_q   <= '0;
				dlm_seen_q  <= 1'b0;
				n_after_q   <= '0;
				hex_hi_q    <= '0;
				hex_lo_q    <= '0;
				sep_pos_q   <= '0;
				sep_seen_q  <= 1'b0;
			end else begin
				line_len_q  <= line_len_d;
				marker_ok_q <= marker_ok_d;
				crc_q       <= crc_d;
				crc_dlm_q   <= crc_dlm_d;
				dlm_pos_q   <= dlm_pos_d;
				dlm_seen_q  <= dlm_seen_d;
				n_after_q   <= n_after_d;
				hex_hi_q    <= hex_hi_d;
				hex_lo_q    <= hex_lo_d;
				sep_pos_q   <= sep_pos_d;
				sep_seen_q  <= sep_seen_d;
			end
		end
	end

	// status for a newline, from the state before it
	logic [4:0]    hv_hi, hv_lo;
	logic [7:0]    expect_crc;
	logic [LW-1:0] payload_w;

	assign hv_hi     = slfc_pkg::hex_val(hex_hi_q);
	assign hv_lo     = slfc_pkg::hex_val(hex_lo_q);
	assign payload_w = dlm_pos_q - sep_pos_q - LW'(1);

	always_comb begin
		if (!hv_hi[4]) begin
			expect_crc = '0;
		end else if (hv_lo[4]) begin
			expect_crc = {hv_hi[3:0], hv_lo[3:0]};
		end else begin
			expect_crc = {4'd0, hv_hi[3:0]};
		end
	end

	always_comb begin
		res.status      = slfc_pkg::ST_IGNORED;
		res.topic_len   = '0;
		res.payload_len = '0;
		res.crc         = '0;
		if (line_len_q != '0 && marker_ok_q) begin
			if (!dlm_seen_q || dlm_pos_q == '0 || n_after_q != 2'd2) begin
				res.status = slfc_pkg::ST_CRC_MISSING;
			end else if (expect_crc != crc_dlm_q) begin
				res.status = slfc_pkg::ST_CRC_BAD;
				res.crc    = crc_dlm_q;
			end else if (sep_seen_q && sep_pos_q != '0 && sep_pos_q < dlm_pos_q) begin
				res.status      = slfc_pkg::ST_ACCEPTED;
				res.crc         = crc_dlm_q;
				res.topic_len   = slfc_pkg::LEN_W'(sep_pos_q);
				res.payload_len = slfc_pkg::LEN_W'(payload_w);
			end else begin
				res.status = slfc_pkg::ST_NO_TOPIC;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/serial_line_frame_checker.sv @@
// An accepted byte is registered, then checked by the per-byte state update; a
// newline's status is registered into res_q and is on the outputs until taken.
// Throughput: one byte per cycle, unless a newline meets an untaken status.
// Reset (arst_n low, asynchronous): line state and handshake flags clear,
// registers return to marker 0, delimiter 0, separator 9.
`default_nettype none

module serial_line_frame_checker #(
	parameter int MAX_LINE = slfc_pkg::MAX_LINE_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [slfc_pkg::BYTE_W-1:0]    rx_byte,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [slfc_pkg::STATUS_W-1:0]       line_status,
	output logic [slfc_pkg::LEN_W-1:0]          topic_length,
	output logic [slfc_pkg::LEN_W-1:0]          payload_length,
	output logic [slfc_pkg::BYTE_W-1:0]         computed_crc,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [slfc_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [slfc_pkg::PDATA_W-1:0]   pwdata,
	output logic [slfc_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready
);

	slfc_pkg::cfg_t cfg_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker    <= slfc_pkg::START_RST;
			cfg_q.crc_delimiter   <= slfc_pkg::DELIM_RST;
			cfg_q.field_separator <= slfc_pkg::SEP_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				slfc_pkg::REG_START: cfg_q.start_marker    <= pwdata[7:0];
				slfc_pkg::REG_DELIM: cfg_q.crc_delimiter   <= pwdata[7:0];
				slfc_pkg::REG_SEP:   cfg_q.field_separator <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			slfc_pkg::REG_START: prdata = {24'd0, cfg_q.start_marker};
			slfc_pkg::REG_DELIM: prdata = {24'd0, cfg_q.crc_delimiter};
			slfc_pkg::REG_SEP:   prdata = {24'd0, cfg_q.field_separator};
			default:             prdata = '0;
		endcase
	end

	logic                          valid_s1;
	logic [slfc_pkg::BYTE_W-1:0]   byte_s1;
	logic                          is_lf_s1;
	logic                          adv_s1;
	logic                          out_valid_q;
	slfc_pkg::result_t             res_c;
	slfc_pkg::result_t             res_q;

	assign is_lf_s1 = (byte_s1 == slfc_pkg::CH_LF);
	assign adv_s1   = valid_s1 && (!is_lf_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	slfc_core #(
		.MAX_LINE (MAX_LINE)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv_s1),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.res     (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && is_lf_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_lf_s1) begin
			res_q <= res_c;
		end
	end

	assign out_valid      = out_valid_q;
	assign line_status    = res_q.status;
	assign topic_length   = res_q.topic_len;
	assign payload_length = res_q.payload_len;
	assign computed_crc   = res_q.crc;

endmodule

`default_nettype wire

@@ rtl/slfc_checker.sv @@
`default_nettype none

module slfc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] line_status,
	input wire logic [8:0] topic_length,
	input wire logic [8:0] payload_length,
	input wire logic [7:0] computed_crc
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(line_status)
			&& $stable(computed_crc))
		else $error("result changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line_status <= slfc_pkg::ST_ACCEPTED)
		else $error("status code out of range");

	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_status != slfc_pkg::ST_ACCEPTED
			|-> topic_length == 9'd0 && payload_length == 9'd0)
		else $error("lengths set on non-accepted line");

	a_crc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (line_status == slfc_pkg::ST_IGNORED
			|| line_status == slfc_pkg::ST_CRC_MISSING
			|| line_status == slfc_pkg::ST_NO_TOPIC) |-> computed_crc == 8'd0)
		else $error("crc reported without crc check");

	a_topic_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_status == slfc_pkg::ST_ACCEPTED |-> topic_length != 9'd0)
		else $error("accepted line without topic");

endmodule

bind serial_line_frame_checker slfc_checker u_slfc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.line_status    (line_status),
	.topic_length   (topic_length),
	.payload_length (payload_length),
	.computed_crc   (computed_crc)
);

`default_nettype wire

@@ dv/tb_serial_line_frame_checker.sv @@
`timescale 1ns / 1ps

module tb_serial_line_frame_checker;
	import slfc_pkg::*;

	localparam int RUN_LIMIT_NS     = 6_000_000;
	localparam int SINK_HOLD_CYCLES = 300;

	typedef enum int {
		TAIL_GOOD,
		TAIL_BAD,
		TAIL_SHORT,
		TAIL_LONG,
		TAIL_NONE,
		TAIL_NONHEX_HI,
		TAIL_NONHEX_LO
	} tail_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [BYTE_W-1:0]   rx_byte;
	logic                out_valid;
	logic                out_ready;
	logic [STATUS_W-1:0] line_status;
	logic [LEN_W-1:0]    topic_length;
	logic [LEN_W-1:0]    payload_length;
	logic [BYTE_W-1:0]   computed_crc;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	int  fail_cnt      = 0;
	int  bytes_sent    = 0;
	int  src_idle_pct  = 20;
	int  sink_idle_pct = 10;
	bit  sink_hold     = 1'b0;

	result_t pending_status[$];

	cfg_t       line_cfg;
	logic [9:0] ln_len;
	bit         mark_hit;
	logic [7:0] crc_run;
	logic [7:0] crc_at_delim;
	logic [9:0] delim_pos;
	bit         delim_hit;
	logic [1:0] tail_cnt;
	logic [7:0] hex_hi;
	logic [7:0] hex_lo;
	logic [9:0] sep_pos;
	bit         sep_hit;

	always #6 clk = ~clk;

	serial_line_frame_checker u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.line_status   (line_status),
		.topic_length  (topic_length),
		.payload_length(payload_length),
		.computed_crc  (computed_crc),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// CRC-8/SMBUS, bit-serial MSB first
	function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] d);
		logic [7:0] r;
		logic       fb;
		r = acc;
		for (int k = 7; k >= 0; k--) begin
			fb = r[7] ^ d[k];
			r = {r[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
		end
		return r;
	endfunction

	function automatic int hex_nibble(input logic [7:0] ch);
		if (ch >= 8'h30 && ch <= 8'h39) begin
			return int'(ch) - 48;
		end else if (ch >= 8'h41 && ch <= 8'h46) begin
			return int'(ch) - 55;
		end else if (ch >= 8'h61 && ch <= 8'h66) begin
			return int'(ch) - 87;
		end
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		if (n < 4'd10) begin
			return 8'h30 + 8'(n);
		end
		return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
	endfunction

	function automatic void clear_line_state();
		ln_len       = '0;
		mark_hit     = 1'b0;
		crc_run      = '0;
		crc_at_delim = '0;
		delim_pos    = '0;
		delim_hit    = 1'b0;
		tail_cnt     = '0;
		hex_hi       = '0;
		hex_lo       = '0;
		sep_pos      = '0;
		sep_hit      = 1'b0;
	endfunction

	function automatic void predict_line_byte(input logic [7:0] c);
		result_t    r;
		int         hi;
		int         lo;
		logic [7:0] want;
		logic [9:0] pos;
		if (c == CH_LF) begin
			r.status      = ST_IGNORED;
			r.topic_len   = '0;
			r.payload_len = '0;
			r.crc         = '0;
			if (ln_len > 0 && mark_hit) begin
				if (!delim_hit || delim_pos == 0 || tail_cnt != 2'd2) begin
					r.status = ST_CRC_MISSING;
				end else begin
					hi   = hex_nibble(hex_hi);
					lo   = hex_nibble(hex_lo);
					want = '0;
					if (hi >= 0) begin
						want = (lo >= 0) ? 8'(hi * 16 + lo) : 8'(hi);
					end
					if (want != crc_at_delim) begin
						r.status = ST_CRC_BAD;
						r.crc    = crc_at_delim;
					end else if (sep_hit && sep_pos > 0 && sep_pos < delim_pos) begin
						r.status      = ST_ACCEPTED;
						r.topic_len   = LEN_W'(sep_pos);
						r.payload_len = LEN_W'(delim_pos - sep_pos - 10'd1);
						r.crc         = crc_at_delim;
					end else begin
						r.status = ST_NO_TOPIC;
					end
				end
			end
			pending_status.push_back(r);
			clear_line_state();
		end else if (c != CH_CR) begin
			if (ln_len == 0) begin
				clear_line_state();
				mark_hit = (c == line_cfg.start_marker);
			end else begin
				pos = ln_len - 10'd1;
				if (c == line_cfg.crc_delimiter) begin
					crc_at_delim = crc_run;
					delim_pos    = pos;
					delim_hit    = 1'b1;
					tail_cnt     = '0;
				end else if (delim_hit) begin
					if (tail_cnt == 2'd0) begin
						hex_hi = c;
					end else if (tail_cnt == 2'd1) begin
						hex_lo = c;
					end
					if (tail_cnt != 2'd3) begin
						tail_cnt = tail_cnt + 2'd1;
					end
				end
				if (c == line_cfg.field_separator && !sep_hit) begin
					sep_hit = 1'b1;
					sep_pos = pos;
				end
				crc_run = crc8_step(crc_run, c);
			end
			ln_len = ln_len + 10'd1;
			if (ln_len > MAX_LINE_DEF) begin
				clear_line_state();
			end
		end
	endfunction

	function automatic logic [7:0] pick_plain_byte();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c == CH_LF || c == CH_CR);
		return c;
	endfunction

	function automatic logic [7:0] pick_data_byte();
		logic [7:0] c;
		do begin
			c = pick_plain_byte();
		end while (c == line_cfg.crc_delimiter || c == line_cfg.field_separator);
		return c;
	endfunction

	function automatic logic [7:0] pick_nonhex();
		logic [7:0] c;
		do begin
			c = pick_plain_byte();
		end while (hex_nibble(c) >= 0 || c == line_cfg.crc_delimiter);
		return c;
	endfunction

	// in_valid is only lowered for a gap or by settle_block, never between back-to-back requests
	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		predict_line_byte(b);
		bytes_sent++;
	endtask

	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {24'd0, val}) begin
			$error("prdata: expected %0h, got %0h", {24'd0, val}, prdata);
			fail_cnt++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_START: line_cfg.start_marker    = val;
			REG_DELIM: line_cfg.crc_delimiter   = val;
			REG_SEP:   line_cfg.field_separator = val;
			default: ;
		endcase
	endtask

	task automatic load_registers(input logic [7:0] m, input logic [7:0] d, input logic [7:0] s);
		settle_block();
		reg_write(REG_START, m);
		reg_write(REG_DELIM, d);
		reg_write(REG_SEP, s);
	endtask

	task automatic send_frame(input int data_len, input int sep_at, input tail_t tail);
		logic [7:0] crc;
		logic [7:0] c;
		logic [7:0] hi;
		logic [7:0] lo;
		bit         upper;
		crc   = '0;
		upper = 1'($urandom_range(0, 1));
		send_byte(line_cfg.start_marker);
		for (int i = 0; i < data_len; i++) begin
			c = (i == sep_at) ? line_cfg.field_separator : pick_data_byte();
			send_byte(c);
			crc = crc8_step(crc, c);
		end
		hi = hex_char(crc[7:4], upper);
		lo = hex_char(crc[3:0], upper);
		case (tail)
			TAIL_BAD:       lo = hex_char(crc[3:0] ^ 4'($urandom_range(1, 15)), upper);
			TAIL_NONHEX_HI: hi = pick_nonhex();
			TAIL_NONHEX_LO: lo = pick_nonhex();
			default: ;
		endcase
		if (tail != TAIL_NONE) begin
			send_byte(line_cfg.crc_delimiter);
			send_byte(hi);
			if (tail != TAIL_SHORT) begin
				send_byte(lo);
			end
			if (tail == TAIL_LONG) begin
				send_byte(hex_char(4'($urandom_range(0, 15)), upper));
			end
		end
		if ($urandom_range(0, 1) == 0) begin
			send_byte(CH_CR);
		end
		send_byte(CH_LF);
	endtask

	task automatic send_noise(input int n);
		for (int i = 0; i < n; i++) begin
			send_byte(8'($urandom_range(0, 255)));
		end
		send_byte(CH_LF);
	endtask

	task automatic test_reset_registers();
		send_byte(CH_LF);
		send_frame(4, 1, TAIL_GOOD);
		send_frame(3, -1, TAIL_BAD);
	endtask

	task automatic test_line_cases();
		load_registers(8'h24, 8'h2A, 8'h3A); // '$' '*' ':'
		send_byte(CH_LF);
		send_byte(CH_CR);
		send_byte(8'h58);
		send_byte(8'h61);
		send_byte(CH_LF);
		send_frame(3, 1, TAIL_NONE);
		send_frame(0, -1, TAIL_GOOD);
		send_frame(3, 1, TAIL_SHORT);
		send_frame(3, 1, TAIL_LONG);
		send_frame(3, 1, TAIL_BAD);
		send_frame(3, -1, TAIL_GOOD);
		send_frame(3, 0, TAIL_GOOD);
		send_frame(4, 2, TAIL_GOOD);
		send_frame(3, 2, TAIL_GOOD);
		send_frame(2, 1, TAIL_NONHEX_HI);
		send_frame(2, 1, TAIL_NONHEX_LO);
		// hex read as prefix: non-hex first digit gives 0, CRC of 0x00 is 0
		send_byte(line_cfg.start_marker);
		send_byte(CH_CR);
		send_byte(8'h00);
		send_byte(line_cfg.crc_delimiter);
		send_byte(8'h78);
		send_byte(8'h78);
		send_byte(CH_LF);
		// single digit '7' matches CRC of 0x01
		send_byte(line_cfg.start_marker);
		send_byte(8'h01);
		send_byte(line_cfg.crc_delimiter);
		send_byte(8'h37);
		send_byte(8'h67);
		send_byte(CH_LF);
	endtask

	task automatic test_separator_is_delimiter();
		load_registers(8'h24, 8'h2A, 8'h2A);
		send_frame(4, 1, TAIL_GOOD);
		send_frame(3, -1, TAIL_GOOD);
		send_frame(3, 0, TAIL_GOOD);
	endtask

	task automatic test_extreme_registers();
		load_registers(8'hFF, 8'hFF, 8'hFF);
		send_frame(4, 2, TAIL_GOOD);
		send_frame(2, -1, TAIL_GOOD);
		load_registers(8'h00, 8'h00, 8'h00);
		send_frame(5, 2, TAIL_GOOD);
		send_frame(3, 1, TAIL_BAD);
		load_registers(8'hFF, 8'h00, 8'h7F);
		send_frame(6, 3, TAIL_GOOD);
	endtask

	// one byte past the limit: the line is dropped and the newline closes an empty line
	task automatic test_overlong_lines();
		load_registers(8'h24, 8'h2A, 8'h3A);
		src_idle_pct = 2;
		send_frame(MAX_LINE_DEF - 3, 100, TAIL_GOOD);
		send_frame(3, 1, TAIL_GOOD);
		src_idle_pct = 20;
	endtask

	task automatic test_output_backpressure();
		settle_block();
		sink_hold = 1'b1;
		for (int i = 0; i < 12; i++) begin
			send_frame(3, 1, TAIL_GOOD);
		end
	endtask

	task automatic load_random_registers();
		logic [7:0] m;
		logic [7:0] d;
		logic [7:0] s;
		m = pick_plain_byte();
		d = pick_plain_byte();
		s = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 5))
			0: begin m = 8'h00; d = 8'h00; s = 8'h00; end
			1: begin m = 8'hFF; d = 8'hFF; s = 8'hFF; end
			2: s = d;
			default: ;
		endcase
		load_registers(m, d, s);
	endtask

	task automatic random_line_traffic(input int n_bytes);
		int stop_at;
		int len;
		int k;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			k   = $urandom_range(0, 99);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
			if (k < 70) begin
				send_frame(len, $urandom_range(0, len), TAIL_GOOD);
			end else if (k < 85) begin
				send_frame(len, $urandom_range(0, len), tail_t'($urandom_range(1, 6)));
			end else begin
				send_noise($urandom_range(0, 12));
			end
		end
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			load_random_registers();
			src_idle_pct  = (phase == 1) ? 0 : $urandom_range(5, 40);
			sink_idle_pct = (phase == 2) ? 0 : $urandom_range(3, 25);
			random_line_traffic(30);
		end
	endtask

	task automatic test_no_idling();
		load_random_registers();
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		random_line_traffic(50);
	endtask

	always @(posedge clk) begin : check_status
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_status.size() == 0) begin
				$error("line_status: nothing expected, got %0d", line_status);
				fail_cnt++;
			end else begin
				want = pending_status.pop_front();
				if (line_status !== want.status) begin
					$error("line_status: expected %0d, got %0d", want.status, line_status);
					fail_cnt++;
				end
				if (topic_length !== want.topic_len) begin
					$error("topic_length: expected %0d, got %0d", want.topic_len, topic_length);
					fail_cnt++;
				end
				if (payload_length !== want.payload_len) begin
					$error("payload_length: expected %0d, got %0d",
						want.payload_len, payload_length);
					fail_cnt++;
				end
				if (computed_crc !== want.crc) begin
					$error("computed_crc: expected %0h, got %0h", want.crc, computed_crc);
					fail_cnt++;
				end
			end
		end
	end

	initial begin : sink_pacing
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold) begin
				out_ready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(posedge clk);
				sink_hold = 1'b0;
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 99) < sink_idle_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		rx_byte  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		line_cfg.start_marker    = START_RST;
		line_cfg.crc_delimiter   = DELIM_RST;
		line_cfg.field_separator = SEP_RST;
		clear_line_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_registers();
		test_line_cases();
		test_separator_is_delimiter();
		test_extreme_registers();
		test_overlong_lines();
		test_output_backpressure();
		test_random_traffic();
		test_no_idling();
		settle_block();

		if (fail_cnt == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
